[rtl/core/paid_pkg.sv]
// ----------------------------------------------------------------------------
// paid_pkg: shared types and constants for the positional array core
// Holds the field widths, operation and status codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package paid_pkg;

  // Storage geometry.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);

  // Field widths of the items.
  localparam int MODE_W = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  // Operation codes carried in the input tuser.
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISPLAY = 2'd2;

  // Status codes carried in the output tuser.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Memory read operations; each one but RD_NONE also sets the walk pointer.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_TOP,
    RD_POS,
    RD_ZERO,
    RD_DEC,
    RD_INC
  } rd_op_t;

  // Memory write operations.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_PUT
  } wr_op_t;

  // Element count updates.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            cap;
    rd_op_t          rd;
    wr_op_t          wr;
    cnt_op_t         cnt;
    logic            st_ld;
    logic [ST_W-1:0] st;
    logic            out_ld;
    logic            out_elem;
  } paid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic ins_at_end;
    logic del_at_end;
    logic ptr_at_pos;
    logic ptr_at_top;
    logic out_free;
  } paid_stat_t;

endpackage

[rtl/core/paid_dp.sv]
// ----------------------------------------------------------------------------
// paid_dp: element store, count and result register
// Holds the element memory with one write and one registered read port, the
// element count, the walk pointer used for shifts and readout, and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module paid_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [paid_pkg::POS_W-1:0]     in_position,
  input  logic [paid_pkg::DATA_W-1:0]    in_value,
  input  paid_pkg::paid_cmd_t            cmd,
  output paid_pkg::paid_stat_t           stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [paid_pkg::ST_W-1:0]      out_status,
  output logic [paid_pkg::CNT_W-1:0]     out_count,
  output logic [paid_pkg::DATA_W-1:0]    out_element,
  output logic                           out_last
);

  logic [paid_pkg::DATA_W-1:0] mem [paid_pkg::CAPACITY];
  logic [paid_pkg::DATA_W-1:0] rdata_r;
  logic [paid_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [paid_pkg::ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [paid_pkg::ADDR_W-1:0] pos_r;
  logic [paid_pkg::DATA_W-1:0] val_r;
  logic [paid_pkg::ST_W-1:0]   st_r;

  logic                        out_valid_r;
  logic [paid_pkg::ST_W-1:0]   out_status_r;
  logic [paid_pkg::CNT_W-1:0]  out_count_r;
  logic [paid_pkg::DATA_W-1:0] out_elem_r;
  logic                        out_last_r;

  logic                        rd_en;
  logic [paid_pkg::ADDR_W-1:0] rd_addr;
  logic                        wr_en;
  logic [paid_pkg::ADDR_W-1:0] wr_addr;
  logic [paid_pkg::DATA_W-1:0] wr_data;
  logic [paid_pkg::CNT_W:0]    count_ext;
  logic [paid_pkg::CNT_W:0]    pos_ext;
  logic [paid_pkg::CNT_W:0]    ptr_ext;
  logic [paid_pkg::ADDR_W-1:0] in_idx;

  // Zero-extended copies for the position and pointer compares.
  assign count_ext = {1'b0, count_r};
  assign pos_ext   = {1'b0, in_position};
  assign ptr_ext   = (paid_pkg::CNT_W + 1)'(ptr_r);
  assign in_idx    = paid_pkg::ADDR_W'(in_position);

  // Status toward the controller.
  always_comb begin
    stat.cnt_zero   = (count_r == '0);
    stat.cnt_full   = (count_ext >= (paid_pkg::CNT_W + 1)'(paid_pkg::CAPACITY));
    stat.ins_pos_ok = (in_position != '0) && (pos_ext <= count_ext + 1'b1);
    stat.del_pos_ok = (in_position != '0) && (pos_ext <= count_ext);
    stat.ins_at_end = (pos_ext == count_ext + 1'b1);
    stat.del_at_end = (pos_ext == count_ext);
    stat.ptr_at_pos = (ptr_r == pos_r);
    stat.ptr_at_top = (ptr_ext + 1'b1 == count_ext);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // Read address and walk pointer update.
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = ptr_r;
    unique case (cmd.rd)
      paid_pkg::RD_NONE: rd_en   = 1'b0;
      paid_pkg::RD_TOP:  rd_addr = paid_pkg::ADDR_W'(count_r - 1'b1);
      paid_pkg::RD_POS:  rd_addr = in_idx;
      paid_pkg::RD_ZERO: rd_addr = '0;
      paid_pkg::RD_DEC:  rd_addr = ptr_r - 1'b1;
      paid_pkg::RD_INC:  rd_addr = ptr_r + 1'b1;
      default:           rd_en   = 1'b0;
    endcase
    ptr_nxt = rd_en ? rd_addr : ptr_r;
  end

  // Write address and data: shift up, shift down or place the new value.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_r;
    wr_data = rdata_r;
    unique case (cmd.wr)
      paid_pkg::WR_NONE: wr_en   = 1'b0;
      paid_pkg::WR_UP:   wr_addr = ptr_r + 1'b1;
      paid_pkg::WR_DOWN: wr_addr = ptr_r - 1'b1;
      paid_pkg::WR_PUT: begin
        wr_addr = pos_r;
        wr_data = val_r;
      end
      default:           wr_en   = 1'b0;
    endcase
  end

  // Count update.
  always_comb begin
    unique case (cmd.cnt)
      paid_pkg::CNT_INC: count_nxt = count_r + 1'b1;
      paid_pkg::CNT_DEC: count_nxt = count_r - 1'b1;
      default:           count_nxt = count_r;
    endcase
  end

  // Element memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.cap) begin
      pos_r <= paid_pkg::ADDR_W'(in_position - 1'b1);
      val_r <= in_value;
    end
    if (cmd.st_ld) begin
      st_r <= cmd.st;
    end
    if (cmd.out_ld) begin
      out_count_r <= count_r;
      if (cmd.out_elem) begin
        out_status_r <= paid_pkg::ST_OK;
        out_elem_r   <= rdata_r;
        out_last_r   <= stat.ptr_at_top;
      end else begin
        out_status_r <= st_r;
        out_elem_r   <= '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;
  assign out_element = out_elem_r;
  assign out_last    = out_last_r;

`ifndef SYNTH
  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_ext <= (paid_pkg::CNT_W + 1)'(paid_pkg::CAPACITY))
    else $error("element count above capacity");

  // An insert never completes into a full store.
  a_no_inc_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt == paid_pkg::CNT_INC) |-> !stat.cnt_full)
    else $error("count raised on a full store");

  // A result is never loaded over one that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> stat.out_free)
    else $error("pending result overwritten");

  // A delete never lowers an empty count.
  a_no_dec_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt == paid_pkg::CNT_DEC) |-> !stat.cnt_zero)
    else $error("count lowered on an empty store");
`endif

endmodule

[rtl/core/paid_ctrl.sv]
// ----------------------------------------------------------------------------
// paid_ctrl: sequencing state machine
// Checks each operation against the count and position, then steps the
// datapath through the shift walk, the value write or the readout, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module paid_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [paid_pkg::MODE_W-1:0]   in_mode,
  output logic                          in_ready,
  input  paid_pkg::paid_stat_t          stat,
  output paid_pkg::paid_cmd_t           cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_SHIFT = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_DEL_SHIFT = 3'd3;
  localparam logic [2:0] S_DISP      = 3'd4;
  localparam logic [2:0] S_RESP      = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    cmd.cap      = 1'b0;
    cmd.rd       = paid_pkg::RD_NONE;
    cmd.wr       = paid_pkg::WR_NONE;
    cmd.cnt      = paid_pkg::CNT_HOLD;
    cmd.st_ld    = 1'b0;
    cmd.st       = paid_pkg::ST_OK;
    cmd.out_ld   = 1'b0;
    cmd.out_elem = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.st_ld = 1'b1;
          state_nxt = S_RESP;
          unique case (in_mode)
            paid_pkg::MODE_INSERT: begin
              if (stat.cnt_full) begin
                cmd.st = paid_pkg::ST_FULL;
              end else if (!stat.ins_pos_ok) begin
                cmd.st = paid_pkg::ST_BADPOS;
              end else begin
                cmd.cap = 1'b1;
                if (stat.ins_at_end) begin
                  state_nxt = S_INS_PUT;
                end else begin
                  cmd.rd    = paid_pkg::RD_TOP;
                  state_nxt = S_INS_SHIFT;
                end
              end
            end
            paid_pkg::MODE_DELETE: begin
              if (stat.cnt_zero) begin
                cmd.st = paid_pkg::ST_EMPTY;
              end else if (!stat.del_pos_ok) begin
                cmd.st = paid_pkg::ST_BADPOS;
              end else if (stat.del_at_end) begin
                cmd.cnt = paid_pkg::CNT_DEC;
              end else begin
                cmd.rd    = paid_pkg::RD_POS;
                state_nxt = S_DEL_SHIFT;
              end
            end
            paid_pkg::MODE_DISPLAY: begin
              if (stat.cnt_zero) begin
                cmd.st = paid_pkg::ST_EMPTY;
              end else begin
                cmd.rd    = paid_pkg::RD_ZERO;
                state_nxt = S_DISP;
              end
            end
            default: begin
              cmd.st = paid_pkg::ST_OK;
            end
          endcase
        end
      end
      // Move one element up per cycle, walking down to the insert point.
      S_INS_SHIFT: begin
        cmd.wr = paid_pkg::WR_UP;
        if (stat.ptr_at_pos) begin
          state_nxt = S_INS_PUT;
        end else begin
          cmd.rd = paid_pkg::RD_DEC;
        end
      end
      S_INS_PUT: begin
        cmd.wr    = paid_pkg::WR_PUT;
        cmd.cnt   = paid_pkg::CNT_INC;
        state_nxt = S_RESP;
      end
      // Move one element down per cycle, walking up to the top.
      S_DEL_SHIFT: begin
        cmd.wr = paid_pkg::WR_DOWN;
        if (stat.ptr_at_top) begin
          cmd.cnt   = paid_pkg::CNT_DEC;
          state_nxt = S_RESP;
        end else begin
          cmd.rd = paid_pkg::RD_INC;
        end
      end
      // Stream elements out; the next read goes out with each load.
      S_DISP: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_elem = 1'b1;
          if (stat.ptr_at_top) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd = paid_pkg::RD_INC;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/positional_array_insert_delete_core.sv]
// ----------------------------------------------------------------------------
// positional_array_insert_delete_core: ordered array with insert and delete
// Keeps up to 64 signed 32-bit elements in order. Insert and delete work at a
// 1-based position and shift the later elements; display streams them out.
//
//   Channel  | Direction | Content
//   in_      | input     | mode in tuser; position, value in tdata
//   out_     | output    | status in tuser; count, element in tdata; last
//
// An insert runs its shift walk, if any, and the value write before the
// result step, a delete its shift walk, if any; a display streams the
// elements out, and a rejected item or unused mode goes to the result
// step. The memory's single read and write port move one element per cycle.
// Synchronous active-low reset clears the count and the channel state; the
// element memory is not cleared. A result waits in the output register
// while the next item is accepted; the display readout and the final result
// step wait while the output register is full and out_tready is low.
// ----------------------------------------------------------------------------
module positional_array_insert_delete_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position [6:0], value [38:7]
  input  logic [1:0]  in_tuser,   // mode [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // count [6:0], element [38:7]
  output logic [1:0]  out_tuser,  // status [1:0]
  output logic        out_tlast
);

  paid_pkg::paid_cmd_t          cmd;
  paid_pkg::paid_stat_t         stat;
  logic [paid_pkg::CNT_W-1:0]   out_count;
  logic [paid_pkg::DATA_W-1:0]  out_element;

  // Sequencer.
  paid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, count and result register.
  paid_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_position (in_tdata[6:0]),
    .in_value    (in_tdata[38:7]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_tuser),
    .out_count   (out_count),
    .out_element (out_element),
    .out_last    (out_tlast)
  );

  // Pack the result fields, lowest first, padded to whole bytes.
  assign out_tdata = {1'b0, out_element, out_count};

endmodule
